// ===== design/tzo_pkg.sv =====
// Shared types and constants of the texel z-buffer occlusion block.
// Used by every module of the block; depends on nothing else.
package tzo_pkg;

    localparam int MAP_ENTRIES = 2097152;
    localparam int DEPTH_BITS  = 20;

    // Fixed field widths.
    localparam int Z_W    = 20;
    localparam int UV_W   = 17;
    localparam int DIM_W  = 13;
    localparam int CELL_W = 12;
    localparam int PROD_W = CELL_W + DIM_W;
    localparam int FULL_W = PROD_W + 1;

    // Depth bits that are kept from a pixel.
    localparam int DEPTH_W = (DEPTH_BITS < Z_W) ? DEPTH_BITS : Z_W;

    localparam int IDX_W   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    // Valid bits are kept in rows of 64 so that a clear sweeps one row a cycle.
    localparam int VBIT_W   = 6;
    localparam int VROW_N   = 1 << VBIT_W;
    localparam int VROWS    = (MAP_ENTRIES + VROW_N - 1) / VROW_N;
    localparam int VROW_AW  = (VROWS > 1) ? $clog2(VROWS) : 1;

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = QA_W + 1;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_CHECK  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_DEPTH_MARGIN = 2'd2;
    localparam logic [1:0] CFG_MIN_DEPTH    = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] map_width;
        logic [DIM_W-1:0] map_height;
        logic [Z_W-1:0]   depth_margin;
        logic [Z_W-1:0]   min_depth;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       op;
        logic             ok;
        logic [IDX_W-1:0] idx;
        logic [Z_W-1:0]   z;
    } t_item;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_IDLE,
        BK_EVAL,
        BK_CLEAR
    } t_back_state;

endpackage

// ===== design/tzo_front.sv =====
// Front part: registers each request, checks pixel validity and forms the texel index.
// Two register stages, the second after the row multiply. Depends on tzo_pkg.
module tzo_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tzo_pkg::t_cfg             i_cfg,
    input  logic                      i_accept,
    input  logic [1:0]                i_operation,
    input  logic [tzo_pkg::Z_W-1:0]   i_depth_z,
    input  logic signed [tzo_pkg::UV_W-1:0] i_tex_u,
    input  logic signed [tzo_pkg::UV_W-1:0] i_tex_v,
    output logic [1:0]                o_inflight,
    output logic                      o_push,
    output tzo_pkg::t_item            o_item
);
    import tzo_pkg::*;

    logic              r_a_vld;
    logic [1:0]        r_a_op;
    logic [Z_W-1:0]    r_a_z;
    logic [UV_W-1:0]   r_a_u;
    logic [UV_W-1:0]   r_a_v;

    logic              r_b_vld;
    logic [1:0]        r_b_op;
    logic [Z_W-1:0]    r_b_z;
    logic              r_b_ok;
    logic [PROD_W-1:0] r_b_prod;
    logic [CELL_W-1:0] r_b_col;

    logic [Z_W-1:0]    z_m;
    logic              a_ok;
    logic [PROD_W-1:0] a_prod;
    logic [FULL_W-1:0] b_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_accept;
            r_b_vld <= r_a_vld;
        end
        if (i_accept) begin
            r_a_op <= i_operation;
            r_a_z  <= i_depth_z;
            r_a_u  <= i_tex_u;
            r_a_v  <= i_tex_v;
        end
        r_b_op   <= r_a_op;
        r_b_z    <= z_m;
        r_b_ok   <= a_ok;
        r_b_prod <= a_prod;
        r_b_col  <= r_a_u[CELL_W+3:4];
    end

    always_comb begin
        z_m    = Z_W'(r_a_z[DEPTH_W-1:0]);
        // Coordinates carry four fraction bits, so the map bound is the size times 16.
        a_ok   = (z_m > i_cfg.min_depth)
                 && !r_a_u[UV_W-1] && !r_a_v[UV_W-1]
                 && (r_a_u != '0) && (r_a_v != '0)
                 && (r_a_u < {i_cfg.map_width, 4'b0000})
                 && (r_a_v < {i_cfg.map_height, 4'b0000});
        a_prod = PROD_W'(r_a_v[CELL_W+3:4]) * PROD_W'(i_cfg.map_width);
        b_full = FULL_W'(r_b_prod) + FULL_W'(r_b_col);
    end

    assign o_push     = r_b_vld;
    assign o_item.op  = r_b_op;
    assign o_item.ok  = r_b_ok && (b_full < FULL_W'(MAP_ENTRIES));
    assign o_item.idx = b_full[IDX_W-1:0];
    assign o_item.z   = r_b_z;
    assign o_inflight = 2'(r_a_vld) + 2'(r_b_vld);

endmodule

// ===== design/tzo_queue.sv =====
// Short request queue between the front and the back part.
// Register based, fixed depth from tzo_pkg.
module tzo_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  tzo_pkg::t_item           i_item,
    input  logic                     i_pop,
    output tzo_pkg::t_item           o_head,
    output logic                     o_empty,
    output logic [tzo_pkg::QC_W-1:0] o_count
);
    import tzo_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QA_W-1:0]  r_wp;
    logic [QA_W-1:0]  r_rp;
    logic [QC_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QC_W'(i_push) - QC_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

// ===== design/tzo_back.sv =====
// Back part: holds the texel depth memory and the row-packed valid memory,
// runs record, check and clear requests and the clearing pass after reset. Depends on tzo_pkg.
module tzo_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tzo_pkg::t_cfg          i_cfg,
    input  tzo_pkg::t_item         i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_init,
    output logic                   o_done,
    output logic                   o_occluded
);
    import tzo_pkg::*;

    logic [Z_W-1:0]    dmem [MAP_ENTRIES];
    logic [VROW_N-1:0] vmem [VROWS];

    t_back_state       r_state;
    t_back_state       n_state;
    logic [VROW_AW-1:0] r_sweep;
    logic [VROW_AW-1:0] n_sweep;
    t_item             r_item;
    logic [Z_W-1:0]    r_dep;
    logic [VROW_N-1:0] r_vrow;
    logic              r_done;
    logic              r_occ;

    logic              rd_en;
    logic              d_we;
    logic              v_we;
    logic [VROW_AW-1:0] v_waddr;
    logic [VROW_N-1:0] v_wdata;
    logic              res_vld;
    logic              res_occ;

    logic              sweeping;
    logic              sweep_last;
    logic              bit_vld;
    logic [Z_W:0]      limit;
    logic [VROW_AW-1:0] item_row;
    logic [VBIT_W-1:0] item_bit;

    assign sweeping   = (r_state == BK_INIT) || (r_state == BK_CLEAR);
    assign sweep_last = (r_sweep == VROW_AW'(VROWS - 1));
    assign item_row   = VROW_AW'(r_item.idx >> VBIT_W);
    assign item_bit   = VBIT_W'(r_item.idx);
    assign bit_vld    = r_vrow[item_bit];
    assign limit      = (Z_W+1)'(r_dep) + (Z_W+1)'(i_cfg.depth_margin);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_INIT, BK_CLEAR: begin
                if (sweep_last) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_empty) begin
                    case (i_head.op) inside
                        OP_CLEAR:            n_state = BK_CLEAR;
                        OP_RECORD, OP_CHECK: n_state = BK_EVAL;
                        default:             n_state = BK_IDLE;
                    endcase
                end
            end
            BK_EVAL: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        d_we    = 1'b0;
        v_we    = 1'b0;
        v_waddr = item_row;
        v_wdata = r_vrow | (VROW_N'(1) << item_bit);
        res_vld = 1'b0;
        res_occ = 1'b0;
        n_sweep = r_sweep;
        unique case (r_state)
            BK_INIT, BK_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_sweep;
                v_wdata = '0;
                n_sweep = sweep_last ? '0 : r_sweep + 1'b1;
            end
            BK_IDLE: begin
                o_pop = !i_empty;
                rd_en = !i_empty;
            end
            BK_EVAL: begin
                if (r_item.op == OP_RECORD) begin
                    // Empty texel takes any depth; filled one only below stored + margin.
                    if (r_item.ok && (!bit_vld || ((Z_W+1)'(r_item.z) < limit))) begin
                        d_we = 1'b1;
                        v_we = 1'b1;
                    end
                end else begin
                    res_vld = 1'b1;
                    res_occ = r_item.ok && bit_vld && (limit < (Z_W+1)'(r_item.z));
                end
            end
            default: begin
                n_sweep = r_sweep;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_INIT;
            r_sweep <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_done  <= res_vld;
        end
        r_occ <= res_occ;
        if (o_pop) begin
            r_item <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            dmem[r_item.idx] <= r_item.z;
        end
        if (rd_en) begin
            r_dep <= dmem[i_head.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_waddr] <= v_wdata;
        end
        if (rd_en) begin
            r_vrow <= vmem[VROW_AW'(i_head.idx >> VBIT_W)];
        end
    end

    assign o_init     = (r_state == BK_INIT) && sweeping;
    assign o_done     = r_done;
    assign o_occluded = r_occ;

endmodule

// ===== design/texel_zbuffer_occlusion.sv =====
// Top level of the texel z-buffer occlusion block: configuration registers,
// request admission and the front, queue and back parts. Depends on tzo_pkg.
//
// A request is taken when start is high and busy is low. A record or check request passes
// the back part's idle state (memory read) and then its eval state (compare and write-back
// on the single port of the depth and valid memories), so the back part takes no new
// request until it is through with the last one. With the queue empty and the back part
// idle, a check request passes the two front stages, the queue, the back read and compare
// states and the done register; its result appears on o_occluded with the o_done strobe
// and holds for one cycle only, since the receiver cannot stall. Requests pass a two-stage
// front part into a four-entry queue; busy rises while four requests sit in the front
// stages and the queue together. A clear sweeps the valid memory one 64-bit row a cycle,
// 32768 rows, while later requests wait in the queue. After reset the same clearing pass
// runs with busy high; configuration writes are taken at all times.
module texel_zbuffer_occlusion (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic [tzo_pkg::Z_W-1:0]       i_depth_z,
    input  logic signed [tzo_pkg::UV_W-1:0] i_tex_u,
    input  logic signed [tzo_pkg::UV_W-1:0] i_tex_v,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [tzo_pkg::Z_W-1:0]       i_cfg_data,
    output logic                          o_done,
    output logic                          o_occluded
);
    import tzo_pkg::*;

    t_cfg            r_cfg;
    logic            accept;
    logic [1:0]      front_cnt;
    logic            push;
    t_item           push_item;
    t_item           head;
    logic            empty;
    logic            pop;
    logic [QC_W-1:0] q_cnt;
    logic            init;
    logic [QC_W:0]   outstanding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width    <= DIM_W'(1920);
            r_cfg.map_height   <= DIM_W'(1080);
            r_cfg.depth_margin <= Z_W'(500);
            r_cfg.min_depth    <= Z_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAP_WIDTH:    r_cfg.map_width    <= i_cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT:   r_cfg.map_height   <= i_cfg_data[DIM_W-1:0];
                CFG_DEPTH_MARGIN: r_cfg.depth_margin <= i_cfg_data;
                CFG_MIN_DEPTH:    r_cfg.min_depth    <= i_cfg_data;
                default:          r_cfg.min_depth    <= r_cfg.min_depth;
            endcase
        end
    end

    // Requests in the front stages count against the queue so that it never overflows.
    assign outstanding = (QC_W+1)'(front_cnt) + (QC_W+1)'(q_cnt);
    assign busy        = init || (outstanding >= (QC_W+1)'(QDEPTH));
    assign accept      = start && !busy;

    tzo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_depth_z   (i_depth_z),
        .i_tex_u     (i_tex_u),
        .i_tex_v     (i_tex_v),
        .o_inflight  (front_cnt),
        .o_push      (push),
        .o_item      (push_item)
    );

    tzo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_count (q_cnt)
    );

    tzo_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (head),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_init     (init),
        .o_done     (o_done),
        .o_occluded (o_occluded)
    );

endmodule

// ===== tb/sv/tzo_occlusion_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for texel_zbuffer_occlusion: mirrors the registers and the texel depth map,
// predicts every check answer and compares it with o_occluded. Depends on tzo_pkg.
module tzo_occlusion_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [1:0]                   i_operation,
    input  logic [tzo_pkg::Z_W-1:0]      i_depth_z,
    input  logic [tzo_pkg::UV_W-1:0]     i_tex_u,
    input  logic [tzo_pkg::UV_W-1:0]     i_tex_v,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [tzo_pkg::Z_W-1:0]      i_cfg_data,
    input  logic                         i_done,
    input  logic                         i_occluded,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_results,
    output int                           o_occluded_cnt
);
    import tzo_pkg::*;

    logic [DIM_W-1:0]   map_w;
    logic [DIM_W-1:0]   map_h;
    logic [Z_W-1:0]     margin;
    logic [Z_W-1:0]     floor_z;

    // A texel is marked valid exactly when it has an entry here.
    logic [DEPTH_W-1:0] depth_store [int];
    bit                 occ_expect_q [$];
    int                 err_cnt;
    int                 result_cnt;
    int                 occ_cnt;

    function automatic bit locate_texel(input logic [Z_W-1:0] z, input logic [UV_W-1:0] u,
                                        input logic [UV_W-1:0] v, output int idx);
        longint unsigned slot;
        idx = 0;
        if (z <= floor_z) return 1'b0;
        if (u[UV_W-1] || v[UV_W-1]) return 1'b0;
        if (u == '0 || v == '0) return 1'b0;
        if (u >= {map_w, 4'b0000} || v >= {map_h, 4'b0000}) return 1'b0;
        slot = 64'(v[UV_W-1:4]);
        slot = slot * 64'(map_w);
        slot = slot + 64'(u[UV_W-1:4]);
        if (slot >= MAP_ENTRIES) return 1'b0;
        idx = int'(slot);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        int           idx;
        bit           ok;
        bit           occ;
        bit           want;
        logic [Z_W:0] reach;
        if (!i_rst_n) begin
            map_w   = 13'd1920;
            map_h   = 13'd1080;
            margin  = 20'd500;
            floor_z = 20'd1;
            depth_store.delete();
            occ_expect_q.delete();
        end else begin
            // Results are compared before this edge's request is added, so a stray
            // strobe can never be matched against a request taken at the same edge.
            if (i_done === 1'b1) begin
                if (occ_expect_q.size() == 0) begin
                    $error("occluded: expected no result, actual %0d", i_occluded);
                    err_cnt++;
                end else begin
                    want = occ_expect_q.pop_front();
                    result_cnt++;
                    if (i_occluded !== want) begin
                        $error("occluded: expected %0d, actual %0d", want, i_occluded);
                        err_cnt++;
                    end
                    if (want) occ_cnt++;
                end
            end else if (i_done !== 1'b0) begin
                $error("done: expected 0 or 1, actual %b", i_done);
                err_cnt++;
            end

            if (i_start && !i_busy) begin
                case (i_operation)
                    OP_CLEAR: depth_store.delete();
                    OP_RECORD: begin
                        ok = locate_texel(i_depth_z, i_tex_u, i_tex_v, idx);
                        if (ok) begin
                            if (!depth_store.exists(idx)) begin
                                depth_store[idx] = i_depth_z[DEPTH_W-1:0];
                            end else begin
                                reach = (Z_W+1)'(depth_store[idx]) + (Z_W+1)'(margin);
                                if (i_depth_z < reach) depth_store[idx] = i_depth_z[DEPTH_W-1:0];
                            end
                        end
                    end
                    OP_CHECK: begin
                        occ = 1'b0;
                        ok  = locate_texel(i_depth_z, i_tex_u, i_tex_v, idx);
                        if (ok && depth_store.exists(idx)) begin
                            reach = (Z_W+1)'(depth_store[idx]) + (Z_W+1)'(margin);
                            occ   = (reach < i_depth_z);
                        end
                        occ_expect_q.push_back(occ);
                    end
                    default: ;
                endcase
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH:    map_w   = i_cfg_data[DIM_W-1:0];
                    CFG_MAP_HEIGHT:   map_h   = i_cfg_data[DIM_W-1:0];
                    CFG_DEPTH_MARGIN: margin  = i_cfg_data;
                    CFG_MIN_DEPTH:    floor_z = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending      <= occ_expect_q.size();
        o_errors       <= err_cnt;
        o_results      <= result_cnt;
        o_occluded_cnt <= occ_cnt;
    end

endmodule

// ===== tb/sv/tb_texel_zbuffer_occlusion.sv =====
`timescale 1ns / 100ps
// Testbench top for texel_zbuffer_occlusion: drives depth pixel requests and register
// writes over several settings and pacings. Depends on tzo_pkg and tzo_occlusion_checker.
module tb_texel_zbuffer_occlusion;
    import tzo_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // A clear, and the pass after reset, sweeps one valid row per cycle.
    localparam int CLEAR_CYCLES = VROWS;
    localparam int MAX_CLEARS   = 8;
    localparam int ITEM_BUDGET  = 1700;
    localparam int CYCLE_LIMIT  = 4 * (CLEAR_CYCLES * (MAX_CLEARS + 3) + ITEM_BUDGET * 64);

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    logic [1:0]         i_operation = OP_RECORD;
    logic [Z_W-1:0]     i_depth_z   = '0;
    logic [UV_W-1:0]    i_tex_u     = '0;
    logic [UV_W-1:0]    i_tex_v     = '0;
    logic               i_cfg_we    = 1'b0;
    logic [1:0]         i_cfg_idx   = CFG_MAP_WIDTH;
    logic [Z_W-1:0]     i_cfg_data  = '0;
    logic               o_done;
    logic               o_occluded;

    int errors;
    int pending;
    int results_cnt;
    int occ_cnt;
    int cycle_cnt   = 0;
    int req_cnt     = 0;
    int setting_cnt = 0;
    int idle_pct    = 0;
    int clears_left = MAX_CLEARS;
    int cur_w;
    int cur_h;
    int cur_margin;
    int cur_floor;

    texel_zbuffer_occlusion uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operation(i_operation),
        .i_depth_z  (i_depth_z),
        .i_tex_u    (i_tex_u),
        .i_tex_v    (i_tex_v),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_occluded (o_occluded)
    );

    tzo_occlusion_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_depth_z     (i_depth_z),
        .i_tex_u       (i_tex_u),
        .i_tex_v       (i_tex_v),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_done        (o_done),
        .i_occluded    (o_occluded),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results_cnt),
        .o_occluded_cnt(occ_cnt)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d answers outstanding.",
                     cycle_cnt, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [Z_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int w, input int h, input int margin, input int floor_z);
        cfg_write(CFG_MAP_WIDTH, Z_W'(w));
        cfg_write(CFG_MAP_HEIGHT, Z_W'(h));
        cfg_write(CFG_DEPTH_MARGIN, Z_W'(margin));
        cfg_write(CFG_MIN_DEPTH, Z_W'(floor_z));
        i_cfg_we   <= 1'b0;
        cur_w      = w % 8192;
        cur_h      = h % 8192;
        cur_margin = margin % (1 << Z_W);
        cur_floor  = floor_z % (1 << Z_W);
        setting_cnt++;
    endtask

    // Holds the request until it is taken, then idles at random with junk on the fields.
    task automatic send_pixel(input logic [1:0] op, input logic [Z_W-1:0] z,
                              input logic [UV_W-1:0] u, input logic [UV_W-1:0] v);
        start       <= 1'b1;
        i_operation <= op;
        i_depth_z   <= z;
        i_tex_u     <= u;
        i_tex_v     <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
        req_cnt++;
        while ($urandom_range(99, 0) < idle_pct) begin
            start       <= 1'b0;
            i_operation <= 2'($urandom);
            i_depth_z   <= Z_W'($urandom);
            i_tex_u     <= UV_W'($urandom);
            i_tex_v     <= UV_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // A final check request cannot answer before everything queued ahead of it,
    // clears included, so its answer marks the block as idle.
    task automatic settle();
        send_pixel(OP_CHECK, Z_W'($urandom), UV_W'($urandom), UV_W'($urandom));
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(999, 0);
        if (r < 6 && clears_left > 0) begin
            clears_left--;
            return OP_CLEAR;
        end
        if (r < 25) return OP_UNUSED;
        if (r < 520) return OP_RECORD;
        return OP_CHECK;
    endfunction

    // Mostly coordinates on a few hot texels so records and checks meet,
    // otherwise raw values and edge cases.
    function automatic logic [UV_W-1:0] pick_coord(input int cells, input bit is_row);
        int r;
        int span;
        int slot;
        r = $urandom_range(99, 0);
        if (r < 80) begin
            span = (cells == 0) ? 4 : cells;
            if (span > 4096) span = 4096;
            if (span <= 8) begin
                slot = $urandom_range(span - 1, 0);
            end else begin
                case ($urandom_range(3, 0))
                    0: slot = $urandom_range(3, 0);
                    1: slot = span - 1 - $urandom_range(3, 0);
                    // Rows around 512 straddle the end of the store on a 4096-wide map.
                    2: slot = (is_row && span > 520) ? 510 + $urandom_range(3, 0)
                                                     : $urandom_range(span - 1, 0);
                    default: slot = $urandom_range(span - 1, 0);
                endcase
            end
            return UV_W'(slot * 16 + $urandom_range(15, 0));
        end
        if (r < 90) return UV_W'($urandom);
        case ($urandom_range(6, 0))
            0: return '0;
            1: return '1;
            2: return 17'h18000;
            3: return 17'h0FFFF;
            4: return UV_W'(cells * 16);
            5: return UV_W'(cells * 16 - 1);
            default: return 17'h10000;
        endcase
    endfunction

    function automatic logic [Z_W-1:0] pick_depth();
        int r;
        int lo;
        int hi;
        r  = $urandom_range(99, 0);
        lo = cur_floor;
        hi = lo + 3 * ((cur_margin > 4000) ? 4000 : cur_margin) + 64;
        if (hi > 20'hFFFFF) hi = 20'hFFFFF;
        if (r < 70) return Z_W'($urandom_range(hi, lo));
        if (r < 85) return Z_W'($urandom);
        case (r % 4)
            0: return '0;
            1: return '1;
            2: return Z_W'(cur_floor);
            default: return Z_W'(cur_floor + 1);
        endcase
    endfunction

    task automatic run_phase(input int w, input int h, input int margin, input int floor_z,
                             input int pace, input int count);
        logic [1:0]      op;
        logic [Z_W-1:0]  z;
        logic [UV_W-1:0] u;
        logic [UV_W-1:0] v;
        apply_settings(w, h, margin, floor_z);
        idle_pct = pace;
        repeat (count) begin
            op = pick_op();
            z  = pick_depth();
            u  = pick_coord(cur_w, 1'b0);
            v  = pick_coord(cur_h, 1'b1);
            send_pixel(op, z, u, v);
        end
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apply_settings(1920, 1080, 500, 1);
        idle_pct = 0;

        // Texel (10, 5) walks through the margin rules on an empty and a filled entry.
        send_pixel(OP_CHECK, 1000, 163, 81);
        send_pixel(OP_RECORD, 1000, 163, 81);
        send_pixel(OP_CHECK, 1500, 163, 81);
        send_pixel(OP_CHECK, 1501, 163, 81);
        send_pixel(OP_RECORD, 1499, 163, 81);
        send_pixel(OP_CHECK, 2000, 163, 81);
        send_pixel(OP_RECORD, 5000, 163, 81);
        send_pixel(OP_CHECK, 1998, 163, 81);
        // Depth at or below the minimum, zero and negative coordinates.
        send_pixel(OP_RECORD, 1, 163, 81);
        send_pixel(OP_CHECK, 1, 163, 81);
        send_pixel(OP_CHECK, 0, 163, 81);
        send_pixel(OP_RECORD, 3000, 0, 81);
        send_pixel(OP_CHECK, 3000, 0, 81);
        send_pixel(OP_CHECK, 3000, 17'h1FFF0, 81);
        send_pixel(OP_CHECK, 3000, 163, 17'h18000);
        // Last texel of the map with the deepest depth, then just past each edge.
        send_pixel(OP_RECORD, 20'hFFFFF, 30719, 17279);
        send_pixel(OP_CHECK, 20'hFFFFF, 30719, 17279);
        send_pixel(OP_CHECK, 3000, 30720, 81);
        send_pixel(OP_CHECK, 3000, 163, 17280);
        send_pixel(OP_UNUSED, 3000, 163, 81);
        send_pixel(OP_CHECK, 3000, 17'h0FFFF, 17'h0FFFF);
        // After a clear the filled texel reads as empty again.
        send_pixel(OP_CLEAR, 0, 0, 0);
        send_pixel(OP_CHECK, 2000, 163, 81);
        send_pixel(OP_RECORD, 800, 163, 81);
        send_pixel(OP_CHECK, 1301, 163, 81);
        settle();

        run_phase(4, 3, 500, 1, 0, 300);
        run_phase(1, 1, 0, 0, 87, 200);
        run_phase(4096, 4096, 20'hFFFFF, 0, 8, 250);
        run_phase(20'hFFFFF, 0, 20'h5A5A5, 20'hAAAAA, 0, 80);
        run_phase(16, 8, 37, 300000, 87, 250);
        run_phase(0, 4096, 2000, 20'hFFFFF, 8, 70);
        run_phase(7, 5, 1, 5, 0, 380);

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests under %0d register settings, %0d clears in the random part.",
                 req_cnt, setting_cnt, MAX_CLEARS - clears_left);
        $display("Compared %0d check answers, %0d of them occluded.", results_cnt, occ_cnt);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
